// ===== hdl/flv_demux_to_annexb_adts_core_assert.svh =====
// Assertion macros for the checker file of the FLV demux core.
`ifndef FLV_DEMUX_TO_ANNEXB_ADTS_CORE_ASSERT_SVH
`define FLV_DEMUX_TO_ANNEXB_ADTS_CORE_ASSERT_SVH
// Same-cycle implication, disabled during reset.
`define FLVAX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define FLVAX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/flvax_pkg.sv =====
// Package: parse phase codes and fixed constants of the FLV demux core.
package flvax_pkg;

  typedef enum logic [15:0] {
    PH_FILE    = 16'h0001,
    PH_PREV    = 16'h0002,
    PH_TAGHDR  = 16'h0004,
    PH_SKIP    = 16'h0008,
    PH_HEAD    = 16'h0010,
    PH_VTYPE   = 16'h0020,
    PH_ATYPE   = 16'h0040,
    PH_CFG     = 16'h0080,
    PH_NALCT   = 16'h0100,
    PH_NALLEN  = 16'h0200,
    PH_NALDATA = 16'h0400,
    PH_SPS     = 16'h0800,
    PH_PPSHEAD = 16'h1000,
    PH_PPS     = 16'h2000,
    PH_ASC     = 16'h4000,
    PH_AACDATA = 16'h8000
  } phase_t;

  localparam logic [7:0] TAG_VIDEO   = 8'h09;
  localparam logic [7:0] TAG_AUDIO   = 8'h08;
  localparam logic [3:0] CODEC_AVC   = 4'd7;
  localparam logic [3:0] FMT_AAC     = 4'd10;
  localparam logic [7:0] PKT_CONFIG  = 8'h00;
  localparam logic [7:0] PKT_DATA    = 8'h01;
  localparam int unsigned MAX_BURST  = 7;
  localparam logic [0:0] KIND_VIDEO  = 1'b0;
  localparam logic [0:0] KIND_AUDIO  = 1'b1;

endpackage

// ===== hdl/flv_demux_to_annexb_adts_core.sv =====
// Top level: FLV byte parser producing Annex B video and ADTS audio bytes.
//
//  channel | dir | handshake             | payload
//  in_     | in  | in_valid / in_ready   | in_byte
//  out_    | out | out_valid / out_ready | out_byte stream_kind unit_start run_last timestamp
//
// Each input byte is parsed in the cycle it is accepted; its results (0 to 7)
// are loaded into a burst register and drained one per cycle while out_ready is high.
// A byte giving no result leaves the input ready; a byte giving results holds off
// the next byte until its last result is taken, the burst register drain being the limit.
// Synchronous active-low reset returns the parser to the file header phase.
// out_ready low stalls the drain and, once a burst is pending, the input.
module flv_demux_to_annexb_adts_core
  import flvax_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        out_stream_kind,
  output logic        out_unit_start,
  output logic        out_run_last,
  output logic [31:0] out_timestamp
);

  // parser state
  phase_t      ph_r, ph_nxt;
  logic [31:0] sc_r, sc_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [7:0]  kind_r, kind_nxt;
  logic [23:0] size_r, size_nxt;
  logic [31:0] tt_r, tt_nxt;
  logic [23:0] off_r, off_nxt;
  logic [2:0]  nps_r, nps_nxt;
  logic [31:0] la_r, la_nxt;
  logic [31:0] ur_r, ur_nxt;
  logic [1:0]  prof_r, prof_nxt;
  logic [3:0]  rate_r, rate_nxt;
  logic [3:0]  ch_r, ch_nxt;

  // burst register
  logic        obusy_r;
  logic [2:0]  oidx_r, ocnt_r;
  logic [7:0]  obuf_r [MAX_BURST];
  logic        okind_r, ostart_r;
  logic [31:0] ots_r;

  logic [2:0]  ecnt;
  logic [7:0]  ebuf [MAX_BURST];
  logic        ekind, estart;
  logic [12:0] alen;
  logic [2:0]  ach;
  logic        olast, in_acc, out_acc;

  assign olast   = (oidx_r == ocnt_r - 3'd1);
  assign in_ready = !obusy_r || (out_ready && olast);
  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  assign alen = size_r[12:0] + 13'd5;
  assign ach  = ch_r[2:0];

  // parse one byte
  always_comb begin
    ph_nxt = ph_r;     sc_nxt = sc_r;     hdr_nxt = hdr_r;   kind_nxt = kind_r;
    size_nxt = size_r; tt_nxt = tt_r;     off_nxt = off_r;   nps_nxt = nps_r;
    la_nxt = la_r;     ur_nxt = ur_r;     prof_nxt = prof_r; rate_nxt = rate_r;
    ch_nxt = ch_r;
    ecnt = 3'd0; ekind = KIND_VIDEO; estart = 1'b0;
    for (int i = 0; i < MAX_BURST; i++) ebuf[i] = 8'h00;
    case (ph_r)
      PH_FILE: begin
        if (sc_r >= 32'd5 && sc_r <= 32'd8) hdr_nxt = {hdr_r[23:0], in_byte};
        sc_nxt = sc_r + 32'd1;
        if (sc_nxt >= 32'd9 && sc_nxt >= hdr_nxt) begin
          ph_nxt = PH_PREV;
          sc_nxt = '0;
        end
      end
      PH_PREV: begin
        sc_nxt = sc_r + 32'd1;
        if (sc_nxt >= 32'd4) begin
          ph_nxt = PH_TAGHDR;
          sc_nxt = '0;
        end
      end
      PH_TAGHDR: begin
        if (sc_r == 32'd0) begin
          kind_nxt = in_byte;
          size_nxt = '0;
          tt_nxt   = '0;
        end else if (sc_r <= 32'd3) begin
          size_nxt = {size_r[15:0], in_byte};
        end else if (sc_r <= 32'd6) begin
          tt_nxt = {8'h00, tt_r[15:0], in_byte};
        end else if (sc_r == 32'd7) begin
          tt_nxt = {in_byte, tt_r[23:0]};
        end
        sc_nxt = sc_r + 32'd1;
        if (sc_nxt >= 32'd11) begin
          sc_nxt  = '0;
          off_nxt = '0;
          ph_nxt  = (size_nxt != 24'd0) ? PH_HEAD : PH_PREV;
        end
      end
      default: begin
        case (ph_r)
          PH_HEAD: begin
            if (kind_r == TAG_VIDEO && in_byte[3:0] == CODEC_AVC) ph_nxt = PH_VTYPE;
            else if (kind_r == TAG_AUDIO && in_byte[7:4] == FMT_AAC) ph_nxt = PH_ATYPE;
            else ph_nxt = PH_SKIP;
          end
          PH_VTYPE: begin
            if (in_byte == PKT_CONFIG) begin
              ph_nxt = PH_CFG;
              la_nxt = '0;
            end else if (in_byte == PKT_DATA) ph_nxt = PH_NALCT;
            else ph_nxt = PH_SKIP;
          end
          PH_CFG: begin
            if (off_r == 24'd9) begin
              nps_nxt = {1'b0, in_byte[1:0]} + 3'd1;
            end else if (off_r == 24'd11) begin
              la_nxt = {24'h0, in_byte};
            end else if (off_r == 24'd12) begin
              la_nxt = {16'h0, la_r[7:0], in_byte};
              ecnt = 3'd4; estart = 1'b1; ebuf[3] = 8'h01;
              ur_nxt = la_nxt;
              sc_nxt = '0;
              ph_nxt = (la_nxt != 32'd0) ? PH_SPS : PH_PPSHEAD;
            end
          end
          PH_SPS: begin
            ecnt = 3'd1; ebuf[0] = in_byte;
            ur_nxt = ur_r - 32'd1;
            if (ur_nxt == 32'd0) begin
              ph_nxt = PH_PPSHEAD;
              sc_nxt = '0;
            end
          end
          PH_PPSHEAD: begin
            if (sc_r == 32'd1) begin
              la_nxt = {24'h0, in_byte};
            end else if (sc_r == 32'd2) begin
              la_nxt = {16'h0, la_r[7:0], in_byte};
              ecnt = 3'd4; estart = 1'b1; ebuf[3] = 8'h01;
              ur_nxt = la_nxt;
              ph_nxt = (la_nxt != 32'd0) ? PH_PPS : PH_SKIP;
            end
            sc_nxt = sc_r + 32'd1;
          end
          PH_PPS: begin
            ecnt = 3'd1; ebuf[0] = in_byte;
            ur_nxt = ur_r - 32'd1;
            if (ur_nxt == 32'd0) ph_nxt = PH_SKIP;
          end
          PH_NALCT: begin
            if (off_r >= 24'd4) begin
              ph_nxt = PH_NALLEN;
              sc_nxt = '0;
              la_nxt = '0;
            end
          end
          PH_NALLEN: begin
            la_nxt = {la_r[23:0], in_byte};
            sc_nxt = sc_r + 32'd1;
            if (sc_nxt >= {29'h0, nps_r}) begin
              ecnt = 3'd4; estart = 1'b1; ebuf[3] = 8'h01;
              ur_nxt = la_nxt;
              ph_nxt = (la_nxt != 32'd0) ? PH_NALDATA : PH_NALLEN;
              sc_nxt = '0;
              la_nxt = '0;
            end
          end
          PH_NALDATA: begin
            ecnt = 3'd1; ebuf[0] = in_byte;
            ur_nxt = ur_r - 32'd1;
            if (ur_nxt == 32'd0) begin
              ph_nxt = PH_NALLEN;
              sc_nxt = '0;
              la_nxt = '0;
            end
          end
          PH_ATYPE: begin
            if (in_byte == PKT_CONFIG) ph_nxt = PH_ASC;
            else if (in_byte == PKT_DATA) begin
              // ADTS header in front of the raw frame
              ecnt = 3'd7; estart = 1'b1; ekind = KIND_AUDIO;
              ebuf[0] = 8'hFF;
              ebuf[1] = 8'hF1;
              ebuf[2] = {prof_r, rate_r, 1'b0, ach[2]};
              ebuf[3] = {ach[1:0], 4'h0, alen[12:11]};
              ebuf[4] = alen[10:3];
              ebuf[5] = {alen[2:0], 5'h1F};
              ebuf[6] = 8'hFC;
              ph_nxt = PH_AACDATA;
            end else ph_nxt = PH_SKIP;
          end
          PH_ASC: begin
            if (off_r == 24'd2) begin
              la_nxt = {24'h0, in_byte};
            end else begin
              prof_nxt = la_r[4:3] - 2'd1;
              rate_nxt = {la_r[2:0], in_byte[7]};
              ch_nxt   = in_byte[6:3];
              ph_nxt   = PH_SKIP;
            end
          end
          PH_AACDATA: begin
            ecnt = 3'd1; ebuf[0] = in_byte; ekind = KIND_AUDIO;
          end
          default: ;
        endcase
        // tag end closes any unit
        off_nxt = off_r + 24'd1;
        if (off_nxt >= size_r) begin
          ph_nxt = PH_PREV;
          sc_nxt = '0;
        end
      end
    endcase
  end

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_FILE; sc_r <= '0; hdr_r <= '0; kind_r <= '0; size_r <= '0;
      tt_r <= '0; off_r <= '0; nps_r <= 3'd4; la_r <= '0; ur_r <= '0;
      prof_r <= '0; rate_r <= '0; ch_r <= '0;
    end else if (in_acc) begin
      ph_r <= ph_nxt; sc_r <= sc_nxt; hdr_r <= hdr_nxt; kind_r <= kind_nxt;
      size_r <= size_nxt; tt_r <= tt_nxt; off_r <= off_nxt; nps_r <= nps_nxt;
      la_r <= la_nxt; ur_r <= ur_nxt; prof_r <= prof_nxt; rate_r <= rate_nxt;
      ch_r <= ch_nxt;
    end
  end

  // burst control; the index stays on the last entry once drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      obusy_r <= 1'b0;
      oidx_r  <= '0;
      ocnt_r  <= '0;
    end else if (in_acc && ecnt != 3'd0) begin
      obusy_r <= 1'b1;
      oidx_r  <= '0;
      ocnt_r  <= ecnt;
    end else if (out_acc) begin
      if (olast) obusy_r <= 1'b0;
      else oidx_r <= oidx_r + 3'd1;
    end
  end

  // burst payload
  always_ff @(posedge clk) begin
    if (in_acc && ecnt != 3'd0) begin
      obuf_r   <= ebuf;
      okind_r  <= ekind;
      ostart_r <= estart;
      ots_r    <= tt_r;
    end
  end

  assign out_valid       = obusy_r;
  assign out_byte        = obuf_r[oidx_r];
  assign out_stream_kind = okind_r;
  assign out_unit_start  = ostart_r && (oidx_r == 3'd0);
  assign out_run_last    = olast;
  assign out_timestamp   = ots_r;

endmodule

// ===== hdl/flvax_checker.sv =====
// Port-level checker for the FLV demux core, bound to the top level.
`include "flv_demux_to_annexb_adts_core_assert.svh"
module flvax_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_byte,
  input logic        out_stream_kind,
  input logic        out_unit_start,
  input logic        out_run_last,
  input logic [31:0] out_timestamp
);
  // stalled result stays valid and its byte holds
  `FLVAX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte), "out stalled payload changed")
  // a burst drains without gaps
  `FLVAX_ASSERT_NEXT(a_burst_cont, out_valid && out_ready && !out_run_last, out_valid && !out_unit_start && $stable(out_timestamp), "burst broken")
  // unit starts open with a start code or sync byte
  `FLVAX_ASSERT_NOW(a_start_byte, out_valid && out_unit_start, (out_stream_kind ? out_byte == 8'hFF : out_byte == 8'h00) && !out_run_last, "bad unit start")
  // no new input while a burst is mid-drain
  `FLVAX_ASSERT_NOW(a_in_block, out_valid && !out_run_last, !in_ready, "input taken during burst")
endmodule

bind flv_demux_to_annexb_adts_core flvax_checker u_flvax_checker (.*);

// ===== tb/tb_flv_demux_to_annexb_adts_core.sv =====
// Testbench: FLV byte stream into the demux core, Annex B / ADTS bytes checked against a predictor.
module tb_flv_demux_to_annexb_adts_core;
  import flvax_pkg::*;

  typedef struct {
    logic [7:0]  es_byte;
    logic        kind;
    logic        start;
    logic        last;
    logic [31:0] ts;
  } es_byte_t;

  typedef struct {
    logic [7:0] b;
    int         first_out;  // -1: no typed expectation
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte;
  logic        out_stream_kind;
  logic        out_unit_start;
  logic        out_run_last;
  logic [31:0] out_timestamp;

  flv_demux_to_annexb_adts_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_byte(out_byte),
    .out_stream_kind(out_stream_kind), .out_unit_start(out_unit_start),
    .out_run_last(out_run_last), .out_timestamp(out_timestamp)
  );

  // Expected elementary stream bytes, oldest first
  es_byte_t   es_expect[$];
  logic [7:0] flv_stream[$];
  int         n_directed;
  int         dir_first[$];
  int         errors = 0;
  int         accepted = 0;
  int         es_seen = 0;
  int         video_units = 0;
  int         adts_frames = 0;
  int         cycles = 0;
  bit         hold_done = 0;
  logic [2:0] gen_prefix = 3'd4;

  // Parser state of the predictor
  phase_t      ph;
  logic [31:0] sec_cnt, hdr_size, tag_ts, len_acc, unit_left;
  logic [7:0]  tag_k;
  logic [23:0] tag_size, pay_off;
  logic [2:0]  prefix_size;
  logic [1:0]  profile_m;
  logic [3:0]  rate_m, chan_m;

  function automatic void push_es(logic [7:0] b, logic k, logic s);
    es_byte_t e;
    e = '{b, k, s, 1'b0, tag_ts};
    es_expect = {es_expect, e};
  endfunction

  function automatic void push_start_code();
    push_es(8'h00, KIND_VIDEO, 1'b1);
    push_es(8'h00, KIND_VIDEO, 1'b0);
    push_es(8'h00, KIND_VIDEO, 1'b0);
    push_es(8'h01, KIND_VIDEO, 1'b0);
    video_units++;
  endfunction

  function automatic void push_adts();
    logic [12:0] flen;
    logic [2:0]  ch;
    flen = 13'(tag_size + 24'd5);
    ch = chan_m[2:0];
    push_es(8'hFF, KIND_AUDIO, 1'b1);
    push_es(8'hF1, KIND_AUDIO, 1'b0);
    push_es({profile_m, rate_m, 1'b0, ch[2]}, KIND_AUDIO, 1'b0);
    push_es({ch[1:0], 4'b0, flen[12:11]}, KIND_AUDIO, 1'b0);
    push_es(flen[10:3], KIND_AUDIO, 1'b0);
    push_es({flen[2:0], 5'h1F}, KIND_AUDIO, 1'b0);
    push_es(8'hFC, KIND_AUDIO, 1'b0);
    adts_frames++;
  endfunction

  function automatic void reset_parser();
    ph = PH_FILE;
    {sec_cnt, hdr_size, tag_ts, len_acc, unit_left} = '0;
    tag_k = '0; tag_size = '0; pay_off = '0;
    prefix_size = 3'd4;
    profile_m = '0; rate_m = '0; chan_m = '0;
  endfunction

  // Advance the parser by one FLV byte, queueing the bytes it produces
  function automatic void parse_flv_byte(logic [7:0] b);
    int n0;
    n0 = es_expect.size();
    if (ph == PH_FILE) begin
      if (sec_cnt >= 5 && sec_cnt <= 8) hdr_size = {hdr_size[23:0], b};
      sec_cnt++;
      if (sec_cnt >= 9 && sec_cnt >= hdr_size) begin
        ph = PH_PREV; sec_cnt = 0;
      end
      return;
    end
    if (ph == PH_PREV) begin
      sec_cnt++;
      if (sec_cnt >= 4) begin
        ph = PH_TAGHDR; sec_cnt = 0;
      end
      return;
    end
    if (ph == PH_TAGHDR) begin
      if (sec_cnt == 0) begin
        tag_k = b; tag_size = '0; tag_ts = '0;
      end else if (sec_cnt <= 3) begin
        tag_size = {tag_size[15:0], b};
      end else if (sec_cnt <= 6) begin
        tag_ts = {8'h00, tag_ts[15:0], b};
      end else if (sec_cnt == 7) begin
        tag_ts[31:24] = b;
      end
      sec_cnt++;
      if (sec_cnt >= 11) begin
        sec_cnt = 0; pay_off = '0;
        ph = (tag_size != 0) ? PH_HEAD : PH_PREV;
      end
      return;
    end
    case (ph)
      PH_HEAD: begin
        if (tag_k == TAG_VIDEO && b[3:0] == CODEC_AVC) ph = PH_VTYPE;
        else if (tag_k == TAG_AUDIO && b[7:4] == FMT_AAC) ph = PH_ATYPE;
        else ph = PH_SKIP;
      end
      PH_VTYPE: begin
        if (b == PKT_CONFIG) begin
          ph = PH_CFG; len_acc = 0;
        end else if (b == PKT_DATA) ph = PH_NALCT;
        else ph = PH_SKIP;
      end
      PH_CFG: begin
        if (pay_off == 9) prefix_size = {1'b0, b[1:0]} + 3'd1;
        else if (pay_off == 11) len_acc = {24'h0, b};
        else if (pay_off == 12) begin
          len_acc = {16'h0, len_acc[7:0], b};
          push_start_code();
          unit_left = len_acc; sec_cnt = 0;
          ph = (unit_left != 0) ? PH_SPS : PH_PPSHEAD;
        end
      end
      PH_SPS: begin
        push_es(b, KIND_VIDEO, 1'b0);
        unit_left--;
        if (unit_left == 0) begin
          ph = PH_PPSHEAD; sec_cnt = 0;
        end
      end
      PH_PPSHEAD: begin
        if (sec_cnt == 1) len_acc = {24'h0, b};
        else if (sec_cnt == 2) begin
          len_acc = {16'h0, len_acc[7:0], b};
          push_start_code();
          unit_left = len_acc;
          ph = (unit_left != 0) ? PH_PPS : PH_SKIP;
        end
        sec_cnt++;
      end
      PH_PPS: begin
        push_es(b, KIND_VIDEO, 1'b0);
        unit_left--;
        if (unit_left == 0) ph = PH_SKIP;
      end
      PH_NALCT: begin
        if (pay_off >= 4) begin
          ph = PH_NALLEN; sec_cnt = 0; len_acc = 0;
        end
      end
      PH_NALLEN: begin
        len_acc = {len_acc[23:0], b};
        sec_cnt++;
        if (sec_cnt >= prefix_size) begin
          push_start_code();
          unit_left = len_acc; sec_cnt = 0; len_acc = 0;
          ph = (unit_left != 0) ? PH_NALDATA : PH_NALLEN;
        end
      end
      PH_NALDATA: begin
        push_es(b, KIND_VIDEO, 1'b0);
        unit_left--;
        if (unit_left == 0) begin
          ph = PH_NALLEN; sec_cnt = 0; len_acc = 0;
        end
      end
      PH_ATYPE: begin
        if (b == PKT_CONFIG) ph = PH_ASC;
        else if (b == PKT_DATA) begin
          push_adts(); ph = PH_AACDATA;
        end else ph = PH_SKIP;
      end
      PH_ASC: begin
        if (pay_off == 2) len_acc = {24'h0, b};
        else begin
          profile_m = 2'((len_acc >> 3) - 1);
          rate_m = {len_acc[2:0], b[7]};
          chan_m = b[6:3];
          ph = PH_SKIP;
        end
      end
      PH_AACDATA: push_es(b, KIND_AUDIO, 1'b0);
      default: ;
    endcase
    pay_off = pay_off + 24'd1;
    if (pay_off >= tag_size) begin
      ph = PH_PREV; sec_cnt = 0;
    end
    if (es_expect.size() > n0) es_expect[es_expect.size()-1].last = 1'b1;
  endfunction

  // Build one random tag (plus trailing size word) onto the stream
  task automatic add_tag();
    logic [7:0] pay[$];
    logic [7:0] kind;
    int         sel, n, sz;
    sel = $urandom_range(0, 9);
    kind = ($urandom_range(0, 1) != 0) ? TAG_VIDEO : TAG_AUDIO;
    case (sel)
      0, 1: begin  // AVC config record
        int ls, lp;
        logic [1:0] lsz;
        kind = TAG_VIDEO;
        lsz = 2'($urandom_range(0, 3));
        gen_prefix = {1'b0, lsz} + 3'd1;
        ls = $urandom_range(0, 5); lp = $urandom_range(0, 4);
        pay = '{8'(($urandom_range(1, 2) << 4) | CODEC_AVC), PKT_CONFIG,
                8'($urandom), 8'($urandom), 8'($urandom), 8'h01, 8'($urandom),
                8'($urandom), 8'($urandom), {6'($urandom), lsz}, 8'hE1,
                8'h00, 8'(ls)};
        repeat (ls) pay = {pay, 8'($urandom)};
        pay = {pay, 8'h01, 8'h00, 8'(lp)};
        repeat (lp) pay = {pay, 8'($urandom)};
        repeat ($urandom_range(0, 3)) pay = {pay, 8'($urandom)};
      end
      2, 3, 4: begin  // length-prefixed NALs
        kind = TAG_VIDEO;
        pay = '{8'(($urandom_range(1, 2) << 4) | CODEC_AVC), PKT_DATA,
                8'($urandom), 8'($urandom), 8'($urandom)};
        repeat ($urandom_range(1, 3)) begin
          n = $urandom_range(0, 6);
          for (int i = gen_prefix - 1; i >= 0; i--) pay = {pay, 8'(n >> (8 * i))};
          repeat (n) pay = {pay, 8'($urandom)};
        end
      end
      5: begin  // AudioSpecificConfig
        kind = TAG_AUDIO;
        pay = '{8'({FMT_AAC, 4'($urandom)}), PKT_CONFIG, 8'($urandom), 8'($urandom)};
      end
      6, 7: begin  // raw AAC frame
        kind = TAG_AUDIO;
        pay = '{8'({FMT_AAC, 4'($urandom)}), PKT_DATA};
        repeat ($urandom_range(0, 8)) pay = {pay, 8'($urandom)};
      end
      8: begin  // unknown packet types or codecs
        pay = '{8'($urandom), 8'($urandom_range(0, 3))};
        repeat ($urandom_range(0, 6)) pay = {pay, 8'($urandom)};
      end
      default: begin  // foreign tag kind, sometimes empty
        kind = 8'($urandom);
        repeat ($urandom_range(0, 5)) pay = {pay, 8'($urandom)};
      end
    endcase
    sz = pay.size();
    if ($urandom_range(0, 5) == 0 && sz > 0) sz = $urandom_range(1, sz);
    flv_stream = {flv_stream, kind, 8'(sz >> 16), 8'(sz >> 8), 8'(sz)};
    repeat (4) flv_stream = {flv_stream, 8'($urandom)};  // timestamp + extended byte
    repeat (3) flv_stream = {flv_stream, 8'($urandom)};  // stream id
    for (int i = 0; i < sz; i++) flv_stream = {flv_stream, pay[i]};
    repeat (4) flv_stream = {flv_stream, 8'($urandom)};
  endtask

  // Directed opening: short header, an ADTS frame at the maximum timestamp, its size word
  dir_row_t dir_tbl[] = '{
    '{8'h46, -1}, '{8'h4C, -1}, '{8'h56, -1}, '{8'h01, -1}, '{8'h05, -1},
    '{8'h00, -1}, '{8'h00, -1}, '{8'h00, -1}, '{8'h05, -1},
    '{8'h00, -1}, '{8'h00, -1}, '{8'h00, -1}, '{8'h00, -1},
    '{TAG_AUDIO, -1}, '{8'h00, -1}, '{8'h00, -1}, '{8'h03, -1},
    '{8'hFF, -1}, '{8'hFF, -1}, '{8'hFF, -1}, '{8'hFF, -1},
    '{8'h00, -1}, '{8'h00, -1}, '{8'h00, -1},
    '{8'hAF, -1}, '{PKT_DATA, 8'hFF}, '{8'h00, 8'h00},
    '{8'h00, -1}, '{8'h00, -1}, '{8'h00, -1}, '{8'h0E, -1}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Check delivered bytes, then feed accepted input to the predictor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      es_seen++;
      if (es_expect.size() == 0) begin
        $error("unexpected output byte %02h", out_byte);
        errors++;
      end else begin
        es_byte_t e;
        e = es_expect.pop_front();
        if (out_byte !== e.es_byte) begin
          $error("out_byte exp %02h got %02h", e.es_byte, out_byte); errors++;
        end
        if (out_stream_kind !== e.kind) begin
          $error("out_stream_kind exp %0d got %0d", e.kind, out_stream_kind); errors++;
        end
        if (out_unit_start !== e.start) begin
          $error("out_unit_start exp %0d got %0d", e.start, out_unit_start); errors++;
        end
        if (out_run_last !== e.last) begin
          $error("out_run_last exp %0d got %0d", e.last, out_run_last); errors++;
        end
        if (out_timestamp !== e.ts) begin
          $error("out_timestamp exp %08h got %08h", e.ts, out_timestamp); errors++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      int n0;
      n0 = es_expect.size();
      parse_flv_byte(in_byte);
      if (accepted < n_directed && dir_first[accepted] >= 0) begin
        if (es_expect.size() <= n0 || es_expect[n0].es_byte != 8'(dir_first[accepted])) begin
          $error("out_byte exp %02h for directed transaction %0d", dir_first[accepted],
                 accepted);
          errors++;
        end
      end
      accepted++;
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles > 200000) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Receiver: random stall pattern, free-running stretches, one long hold-off
  initial begin
    int hold, seg;
    bit free_run;
    hold = 0; seg = 0; free_run = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        hold--;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted >= 150) begin
        hold_done = 1;
        hold = 300;
        out_ready <= 1'b0;
      end else begin
        if (seg == 0) begin
          seg = $urandom_range(20, 80);
          free_run = ($urandom_range(0, 2) == 0);
        end
        seg--;
        out_ready <= free_run ? 1'b1 : ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Sender: bursts of transactions, some separated by random gaps
  initial begin
    int burst;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_byte = 8'h00;
    reset_parser();
    n_directed = dir_tbl.size();
    foreach (dir_tbl[i]) begin
      flv_stream = {flv_stream, dir_tbl[i].b};
      dir_first = {dir_first, dir_tbl[i].first_out};
    end
    while (flv_stream.size() < 350) add_tag();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    burst = 0;
    while (flv_stream.size() > 0) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        if ($urandom_range(0, 1) != 0) begin
          in_valid <= 1'b0;
          repeat ($urandom_range(1, 6)) @(negedge clk);
        end
      end
      burst--;
      in_valid <= 1'b1;
      in_byte <= flv_stream.pop_front();
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      @(negedge clk);
    end
    in_valid <= 1'b0;
    while (es_expect.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("Fed %0d FLV bytes; checked %0d output bytes (%0d start codes, %0d ADTS headers).",
             accepted, es_seen, video_units, adts_frames);
    if (errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/flvax_pkg.sv
hdl/flv_demux_to_annexb_adts_core.sv
hdl/flvax_checker.sv
tb/tb_flv_demux_to_annexb_adts_core.sv
